@@ rtl/rfd_pkg.sv @@
// Package for the reader frame deframer: event codes, parser phases and the
// records passed between the queues. Used by every module in rtl/.
`timescale 1ns / 1ps

package rfd_pkg;

  // Depth of each of the two-entry queues.
  localparam logic [1:0] Q_DEPTH = 2'd2;

  // Byte values that mark start codes, ACK, NACK and extended lengths.
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  // Register reset value of the expected frame type.
  localparam logic [7:0] TYPE_RESET = 8'hD5;

  // Event codes reported once per received byte.
  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_ACK      = 4'd1,
    EV_NACK     = 4'd2,
    EV_LEN_BAD  = 4'd3,
    EV_TYPE_BAD = 4'd4,
    EV_OPEN     = 4'd5,
    EV_PAYLOAD  = 4'd6,
    EV_ERROR    = 4'd7,
    EV_DCS_OK   = 4'd8,
    EV_DCS_BAD  = 4'd9,
    EV_END      = 4'd10
  } event_t;

  // Parser phases, one-hot.
  typedef enum logic [10:0] {
    PH_HUNT     = 11'b000_0000_0001,
    PH_LEN      = 11'b000_0000_0010,
    PH_LCS      = 11'b000_0000_0100,
    PH_EXT_HIGH = 11'b000_0000_1000,
    PH_EXT_LOW  = 11'b000_0001_0000,
    PH_EXT_LCS  = 11'b000_0010_0000,
    PH_TYPE     = 11'b000_0100_0000,
    PH_DATA     = 11'b000_1000_0000,
    PH_ERRCODE  = 11'b001_0000_0000,
    PH_DCS      = 11'b010_0000_0000,
    PH_POST     = 11'b100_0000_0000
  } phase_t;

  // A received byte with its classification flags.
  typedef struct packed {
    logic [7:0] data;
    logic       is_zero;
    logic       is_ones;
  } rx_item_t;

  // Handshake from the front queue toward the parser.
  typedef struct packed {
    logic     empty;
    rx_item_t item;
  } front_status_t;

  // One reported event.
  typedef struct packed {
    event_t     ev;
    logic [7:0] value;
  } result_t;

endpackage

@@ rtl/rfd_front.sv @@
// Front part of the reader frame deframer: classifies received bytes and
// holds them in a two-entry queue. Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  logic [7:0]             rx_byte,
  output logic                   full,
  input  logic                   pop,
  output rfd_pkg::front_status_t status
);

  rfd_pkg::rx_item_t mem_r [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;
  rfd_pkg::rx_item_t new_item;

  // Classify the incoming byte as it enters.
  always_comb begin
    new_item.data    = rx_byte;
    new_item.is_zero = (rx_byte == rfd_pkg::BYTE_ZERO);
    new_item.is_ones = (rx_byte == rfd_pkg::BYTE_ONES);
  end

  assign full    = (count_r == rfd_pkg::Q_DEPTH);
  assign do_push = push && !full;
  assign do_pop  = pop && (count_r != 2'd0);

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  assign status.empty = (count_r == 2'd0);
  assign status.item  = mem_r[rd_ptr_r];

endmodule

@@ rtl/rfd_back.sv @@
// Back part of the reader frame deframer: the frame parser state machine,
// the expected-type register and a two-entry result queue. Depends on rfd_pkg.
`timescale 1ns / 1ps

module rfd_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_wdata,
  input  rfd_pkg::front_status_t front,
  output logic                   front_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output rfd_pkg::result_t       out_head
);

  rfd_pkg::phase_t   phase_r, phase_nxt;
  logic [7:0]        held_byte_r, held_byte_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic [7:0]        length_high_r, length_high_nxt;
  logic [15:0]       remaining_r, remaining_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic [7:0]        type_r;
  rfd_pkg::result_t  res;
  logic [7:0]        b;
  logic [7:0]        short_sum;
  logic [7:0]        ext_sum;
  logic [7:0]        dcs_sum;
  logic [15:0]       rem_dec;
  logic              take;

  rfd_pkg::result_t  oq_r [2];
  logic              oq_wr_r, oq_rd_r;
  logic [1:0]        oq_count_r, oq_count_nxt;
  logic              oq_pop;

  // A byte is parsed whenever one is queued and the result queue has room.
  assign take   = !front.empty && (oq_count_r != rfd_pkg::Q_DEPTH);
  assign front_pop = take;
  assign b      = front.item.data;

  assign short_sum = held_byte_r + b;
  assign ext_sum   = length_high_r + held_byte_r + b;
  assign dcs_sum   = sum_r + b;
  assign rem_dec   = (remaining_r != 16'd0) ? (remaining_r - 16'd1) : remaining_r;

  // Expected frame type register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r <= rfd_pkg::TYPE_RESET;
    end else if (cfg_we) begin
      type_r <= cfg_wdata;
    end
  end

  // Parser next-state and event logic for the byte at the queue head.
  always_comb begin
    phase_nxt       = phase_r;
    held_byte_nxt   = held_byte_r;
    held_valid_nxt  = held_valid_r;
    length_high_nxt = length_high_r;
    remaining_nxt   = remaining_r;
    sum_nxt         = sum_r;
    res.ev          = rfd_pkg::EV_NONE;
    res.value       = 8'd0;
    unique case (phase_r)
      rfd_pkg::PH_HUNT: begin
        if (held_valid_r && (held_byte_r == rfd_pkg::BYTE_ZERO) && front.item.is_ones) begin
          phase_nxt      = rfd_pkg::PH_LEN;
          held_valid_nxt = 1'b0;
        end else begin
          held_byte_nxt  = b;
          held_valid_nxt = 1'b1;
        end
      end
      rfd_pkg::PH_LEN: begin
        held_byte_nxt = b;
        phase_nxt     = rfd_pkg::PH_LCS;
      end
      rfd_pkg::PH_LCS: begin
        // ACK, NACK and extended codes take precedence over the length check.
        priority if ((held_byte_r == rfd_pkg::BYTE_ZERO) && front.item.is_ones) begin
          res.ev    = rfd_pkg::EV_ACK;
          phase_nxt = rfd_pkg::PH_POST;
        end else if ((held_byte_r == rfd_pkg::BYTE_ONES) && front.item.is_zero) begin
          res.ev    = rfd_pkg::EV_NACK;
          phase_nxt = rfd_pkg::PH_POST;
        end else if ((held_byte_r == rfd_pkg::BYTE_ONES) && front.item.is_ones) begin
          phase_nxt = rfd_pkg::PH_EXT_HIGH;
        end else if ((short_sum != 8'd0) || (held_byte_r == 8'd0)) begin
          res.ev         = rfd_pkg::EV_LEN_BAD;
          phase_nxt      = rfd_pkg::PH_HUNT;
          held_valid_nxt = 1'b0;
        end else if (held_byte_r == 8'd1) begin
          phase_nxt = rfd_pkg::PH_ERRCODE;
        end else begin
          remaining_nxt = {8'd0, held_byte_r - 8'd1};
          phase_nxt     = rfd_pkg::PH_TYPE;
        end
      end
      rfd_pkg::PH_EXT_HIGH: begin
        length_high_nxt = b;
        phase_nxt       = rfd_pkg::PH_EXT_LOW;
      end
      rfd_pkg::PH_EXT_LOW: begin
        held_byte_nxt = b;
        phase_nxt     = rfd_pkg::PH_EXT_LCS;
      end
      rfd_pkg::PH_EXT_LCS: begin
        if ((ext_sum != 8'd0) || ({length_high_r, held_byte_r} == 16'd0)) begin
          res.ev         = rfd_pkg::EV_LEN_BAD;
          phase_nxt      = rfd_pkg::PH_HUNT;
          held_valid_nxt = 1'b0;
        end else begin
          remaining_nxt = {length_high_r, held_byte_r} - 16'd1;
          phase_nxt     = rfd_pkg::PH_TYPE;
        end
      end
      rfd_pkg::PH_TYPE: begin
        res.value = b;
        sum_nxt   = b;
        if (b == type_r) begin
          res.ev    = rfd_pkg::EV_OPEN;
          phase_nxt = (remaining_r == 16'd0) ? rfd_pkg::PH_DCS : rfd_pkg::PH_DATA;
        end else begin
          res.ev         = rfd_pkg::EV_TYPE_BAD;
          phase_nxt      = rfd_pkg::PH_HUNT;
          held_valid_nxt = 1'b0;
        end
      end
      rfd_pkg::PH_DATA: begin
        res.ev        = rfd_pkg::EV_PAYLOAD;
        res.value     = b;
        sum_nxt       = dcs_sum;
        remaining_nxt = rem_dec;
        if (rem_dec == 16'd0) begin
          phase_nxt = rfd_pkg::PH_DCS;
        end
      end
      rfd_pkg::PH_ERRCODE: begin
        res.ev    = rfd_pkg::EV_ERROR;
        res.value = b;
        sum_nxt   = b;
        phase_nxt = rfd_pkg::PH_DCS;
      end
      rfd_pkg::PH_DCS: begin
        res.ev    = (dcs_sum == 8'd0) ? rfd_pkg::EV_DCS_OK : rfd_pkg::EV_DCS_BAD;
        phase_nxt = rfd_pkg::PH_POST;
      end
      rfd_pkg::PH_POST: begin
        res.ev         = rfd_pkg::EV_END;
        phase_nxt      = rfd_pkg::PH_HUNT;
        held_valid_nxt = 1'b0;
      end
      default: begin
        phase_nxt      = rfd_pkg::PH_HUNT;
        held_valid_nxt = 1'b0;
      end
    endcase
  end

  // Parser state registers advance only when a byte is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= rfd_pkg::PH_HUNT;
      held_byte_r   <= 8'd0;
      held_valid_r  <= 1'b0;
      length_high_r <= 8'd0;
      remaining_r   <= 16'd0;
      sum_r         <= 8'd0;
    end else if (take) begin
      phase_r       <= phase_nxt;
      held_byte_r   <= held_byte_nxt;
      held_valid_r  <= held_valid_nxt;
      length_high_r <= length_high_nxt;
      remaining_r   <= remaining_nxt;
      sum_r         <= sum_nxt;
    end
  end

  // Result queue: one entry per parsed byte.
  assign oq_pop       = out_pop && (oq_count_r != 2'd0);
  assign oq_count_nxt = oq_count_r + {1'b0, take} - {1'b0, oq_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= 1'b0;
      oq_rd_r    <= 1'b0;
      oq_count_r <= 2'd0;
    end else begin
      if (take) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (oq_pop) begin
        oq_rd_r <= ~oq_rd_r;
      end
      oq_count_r <= oq_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      oq_r[oq_wr_r] <= res;
    end
  end

  assign out_empty = (oq_count_r == 2'd0);
  assign out_head  = oq_r[oq_rd_r];

endmodule

@@ rtl/reader_frame_deframer_top.sv @@
// Top level of the reader frame deframer: joins the classifying front queue
// and the parser back end. Depends on rfd_pkg, rfd_front and rfd_back.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                   Handshake
// input     in         in_rx_byte                              in_push / in_full
// result    out        out_event_res, out_value                out_empty / out_pop
// config    in         cfg_wdata                               cfg_we
//
// One item is accepted and one result produced per cycle when out_pop keeps up.
// A byte reaches the result ports through both queues: the accepting edge
// writes the input queue, and an edge on which the result queue has room
// moves the byte through the parser into the result queue.
// The parser takes a byte only when the result queue has room, so a stalled
// reader fills both queues and then raises in_full.
// Reset is synchronous and active low; it empties both queues and restarts
// the start-code hunt with the expected frame type at 0xD5.

module reader_frame_deframer_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_rx_byte,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [3:0] out_event_res,
  output logic [7:0] out_value,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  rfd_pkg::front_status_t front_status;
  logic                   front_pop;
  rfd_pkg::result_t       out_head;

  // Front part: byte classification and input queue.
  rfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .rx_byte (in_rx_byte),
    .full    (in_full),
    .pop     (front_pop),
    .status  (front_status)
  );

  // Back part: frame parser and result queue.
  rfd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .front     (front_status),
    .front_pop (front_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_head  (out_head)
  );

  assign out_event_res = out_head.ev;
  assign out_value     = out_head.value;

`ifndef SYNTHESIS
  // The parser never takes a byte from an empty front queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    front_pop |-> !front_status.empty)
    else $error("parser popped an empty front queue");

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // The value field is zero unless the event carries a byte.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !(out_event_res == rfd_pkg::EV_TYPE_BAD ||
                     out_event_res == rfd_pkg::EV_OPEN ||
                     out_event_res == rfd_pkg::EV_PAYLOAD ||
                     out_event_res == rfd_pkg::EV_ERROR)) |-> (out_value == 8'd0))
    else $error("value nonzero for an event without a byte");
`endif

endmodule
